// ----- hdl/rvcc_pkg.sv -----
package rvcc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_CAM_X       = 3'd0;
    localparam logic [2:0] REG_CAM_Y       = 3'd1;
    localparam logic [2:0] REG_CAM_Z       = 3'd2;
    localparam logic [2:0] REG_DIR_X       = 3'd3;
    localparam logic [2:0] REG_DIR_Y       = 3'd4;
    localparam logic [2:0] REG_DIR_Z       = 3'd5;
    localparam logic [2:0] REG_COS_FOV     = 3'd6;
    localparam logic [2:0] REG_CULL_ENABLE = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 24;
    localparam int SIZE_W     = 23;
    localparam int DIR_W      = 16;
    localparam int DELTA_W    = 26;
    localparam int COUNT_W    = 11;
    localparam int L2_W       = 28;

    // Squared view and near distances, 8 fraction bits on each side.
    localparam logic signed [63:0] FAR_L2  = 64'sd163840000;
    localparam logic [L2_W-1:0]    NEAR_L2 = 28'd26214400;

    typedef logic [4:0] step_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DXDX,
        MUL_DYDY,
        MUL_DZDZ,
        MUL_XD,
        MUL_YD,
        MUL_ZD,
        MUL_CC,
        MUL_DD,
        MUL_CCL
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        LAT_NONE,
        LAT_L2,
        LAT_D,
        LAT_CC,
        LAT_LHS
    } lat_op_t;

    typedef enum logic [1:0] {
        DP_NONE,
        DP_CORNER,
        DP_DELTA
    } dp_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_OFF,
        J_FAR,
        J_NEAR
    } cond_t;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_PASS,
        FIN_HIDE,
        FIN_SHOW,
        FIN_CONE
    } fin_t;

    typedef struct packed {
        dp_op_t   dp;
        mul_sel_t mul;
        acc_op_t  acc;
        lat_op_t  lat;
        cond_t    cond;
        step_t    target;
        fin_t     fin;
    } ctl_t;

    localparam step_t STEP_FIRST = 5'd0;
    localparam step_t STEP_PASS  = 5'd15;
    localparam step_t STEP_HIDE  = 5'd16;
    localparam step_t STEP_SHOW  = 5'd17;

    localparam ctl_t CTL_NOP = '{
        dp: DP_NONE, mul: MUL_NONE, acc: ACC_HOLD, lat: LAT_NONE,
        cond: J_NEXT, target: STEP_FIRST, fin: FIN_NONE
    };

    // Microcode. The multiplier result lands one step after it is issued.
    function automatic ctl_t ucode(input step_t s);
        ctl_t c;
        begin
            c = CTL_NOP;
            case (s)
                5'd0:
                begin
                    c.dp     = DP_CORNER;
                    c.cond   = J_OFF;
                    c.target = STEP_PASS;
                end
                5'd1:  c.dp = DP_DELTA;
                5'd2:  c.mul = MUL_DXDX;
                5'd3:
                begin
                    c.mul = MUL_DYDY;
                    c.acc = ACC_LOAD;
                end
                5'd4:
                begin
                    c.mul = MUL_DZDZ;
                    c.acc = ACC_ADD;
                end
                5'd5:  c.acc = ACC_ADD;
                5'd6:
                begin
                    c.lat    = LAT_L2;
                    c.cond   = J_FAR;
                    c.target = STEP_HIDE;
                end
                5'd7:
                begin
                    c.mul    = MUL_XD;
                    c.cond   = J_NEAR;
                    c.target = STEP_SHOW;
                end
                5'd8:
                begin
                    c.mul = MUL_YD;
                    c.acc = ACC_LOAD;
                end
                5'd9:
                begin
                    c.mul = MUL_ZD;
                    c.acc = ACC_ADD;
                end
                5'd10: c.acc = ACC_ADD;
                5'd11:
                begin
                    c.lat = LAT_D;
                    c.mul = MUL_CC;
                end
                5'd12:
                begin
                    c.lat = LAT_CC;
                    c.mul = MUL_DD;
                end
                5'd13:
                begin
                    c.lat = LAT_LHS;
                    c.mul = MUL_CCL;
                end
                5'd14: c.fin = FIN_CONE;
                5'd15: c.fin = FIN_PASS;
                5'd16: c.fin = FIN_HIDE;
                5'd17: c.fin = FIN_SHOW;
                default: c.fin = FIN_HIDE;
            endcase
            return c;
        end
    endfunction

endpackage

// ----- hdl/rvcc_if.sv -----
interface rvcc_in_if;
    logic                     valid;
    logic                     ready;
    logic                     frame_start;
    logic signed [23:0]       room_x;
    logic signed [23:0]       room_y;
    logic signed [23:0]       room_z;
    logic [22:0]              size_x;
    logic [22:0]              size_y;
    logic [22:0]              size_z;

    modport source (
        output valid, frame_start, room_x, room_y, room_z, size_x, size_y, size_z,
        input  ready
    );
    modport sink (
        input  valid, frame_start, room_x, room_y, room_z, size_x, size_y, size_z,
        output ready
    );
endinterface

interface rvcc_out_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic        checked;
    logic [10:0] rendered_count;

    modport source (
        output valid, visible, checked, rendered_count,
        input  ready
    );
    modport sink (
        input  valid, visible, checked, rendered_count,
        output ready
    );
endinterface

// ----- hdl/room_view_cone_cull_top.sv -----
// Room distance and view-cone culling.
// The room channel carries one room box per transaction: a frame_start flag,
// the origin and the size. The result channel returns one transaction per
// room: visible, checked and the count of checked visible rooms in the frame so far.
// Camera position, forward vector, cosine of the view angle and the culling
// enable are written on the cfg_en/cfg_addr/cfg_data port; the user must
// write them only while no room is in flight, as the block does not enforce it.
// Each room runs through a microcoded program on one shared 32x32 multiplier.
// The result is registered when the program ends: early with culling off,
// after the view-distance check for a room beyond the view distance, after
// the near check for one inside the near distance, and after the cone test
// otherwise. One room is worked on at a time; the next is accepted in the
// cycle after the previous result is registered.
// When the receiver stalls, a finished result waits in the output register
// and the program holds on its final step until the register frees up.
// Reset loads the register defaults, clears the count and empties the block.
module room_view_cone_cull_top #(
    parameter int MAX_ROOMS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_en,
    input  logic [rvcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rvcc_pkg::CFG_DATA_W-1:0] cfg_data,
    rvcc_in_if.sink                         room,
    rvcc_out_if.source                      result
);

    localparam logic [rvcc_pkg::COUNT_W-1:0] COUNT_CAP =
        (MAX_ROOMS > 2047) ? 11'd2047 : 11'(MAX_ROOMS);

    // Configuration.
    logic signed [rvcc_pkg::POS_W-1:0]   cam_reg [3];
    logic signed [rvcc_pkg::DIR_W-1:0]   dir_reg [3];
    logic signed [rvcc_pkg::DIR_W-1:0]   cos_reg;
    logic                                cull_reg;

    // Sequencer and result.
    logic                                busy_reg;
    rvcc_pkg::step_t                     step_reg;
    rvcc_pkg::step_t                     step_next;
    logic                                ovalid_reg;
    logic                                vis_reg;
    logic                                chk_reg;
    logic [rvcc_pkg::COUNT_W-1:0]        count_reg;
    logic [rvcc_pkg::COUNT_W-1:0]        count_next;

    // Datapath.
    logic                                fs_reg;
    logic signed [rvcc_pkg::POS_W-1:0]   room_reg [3];
    logic [rvcc_pkg::SIZE_W-1:0]         size_reg [3];
    logic signed [rvcc_pkg::DELTA_W-1:0] dlt_reg [3];
    logic signed [63:0]                  prod_reg;
    logic signed [63:0]                  acc_reg;
    logic [rvcc_pkg::L2_W-1:0]           l2_reg;
    logic signed [31:0]                  d_reg;
    logic [30:0]                         cc2_reg;
    logic [61:0]                         lhs_reg;

    rvcc_pkg::ctl_t                      ctl;
    logic                                in_go;
    logic                                jump;
    logic                                fin_go;
    logic                                advance;
    logic signed [31:0]                  mul_a;
    logic signed [31:0]                  mul_b;
    logic signed [16:0]                  cos_ext;
    logic [16:0]                         cc_abs;
    logic [31:0]                         d_abs;
    logic [61:0]                         rhs;
    logic                                cone_ok;
    logic                                vis_new;
    logic                                chk_new;
    logic [rvcc_pkg::COUNT_W-1:0]        count_base;

    assign in_go      = room.valid && room.ready;
    assign room.ready = !busy_reg;

    assign result.valid          = ovalid_reg;
    assign result.visible        = vis_reg;
    assign result.checked        = chk_reg;
    assign result.rendered_count = count_reg;

    always_comb
    begin
        ctl     = rvcc_pkg::ucode(step_reg);
        cos_ext = 17'(cos_reg);
        cc_abs  = cos_ext[16] ? 17'(-cos_ext) : 17'(cos_ext);
        d_abs   = d_reg[31] ? 32'(-d_reg) : 32'(d_reg);
        rhs     = 62'(prod_reg);

        unique case (ctl.cond)
            rvcc_pkg::J_NEXT: jump = 1'b0;
            rvcc_pkg::J_OFF:  jump = !cull_reg;
            rvcc_pkg::J_FAR:  jump = acc_reg >= rvcc_pkg::FAR_L2;
            rvcc_pkg::J_NEAR: jump = l2_reg < rvcc_pkg::NEAR_L2;
            default:          jump = 1'b0;
        endcase

        fin_go  = busy_reg && (ctl.fin != rvcc_pkg::FIN_NONE)
                  && (!ovalid_reg || result.ready);
        advance = busy_reg && ((ctl.fin == rvcc_pkg::FIN_NONE) || fin_go);
        step_next = jump ? ctl.target : step_reg + 5'd1;

        unique case (ctl.mul)
            rvcc_pkg::MUL_DXDX: begin mul_a = 32'(dlt_reg[0]); mul_b = 32'(dlt_reg[0]); end
            rvcc_pkg::MUL_DYDY: begin mul_a = 32'(dlt_reg[1]); mul_b = 32'(dlt_reg[1]); end
            rvcc_pkg::MUL_DZDZ: begin mul_a = 32'(dlt_reg[2]); mul_b = 32'(dlt_reg[2]); end
            rvcc_pkg::MUL_XD:   begin mul_a = 32'(dir_reg[0]); mul_b = 32'(dlt_reg[0]); end
            rvcc_pkg::MUL_YD:   begin mul_a = 32'(dir_reg[1]); mul_b = 32'(dlt_reg[1]); end
            rvcc_pkg::MUL_ZD:   begin mul_a = 32'(dir_reg[2]); mul_b = 32'(dlt_reg[2]); end
            rvcc_pkg::MUL_CC:
            begin
                mul_a = $signed({15'd0, cc_abs});
                mul_b = $signed({15'd0, cc_abs});
            end
            rvcc_pkg::MUL_DD:
            begin
                mul_a = $signed(d_abs);
                mul_b = $signed(d_abs);
            end
            rvcc_pkg::MUL_CCL:
            begin
                mul_a = $signed({1'b0, cc2_reg});
                mul_b = $signed({4'd0, l2_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // Sign-aware squared compare of dir.dp against cos_fov * |dp|.
        if (!d_reg[31])
        begin
            cone_ok = (cos_reg <= 16'sd0) || (lhs_reg >= rhs);
        end
        else
        begin
            cone_ok = (cos_reg < 16'sd0) && (lhs_reg <= rhs);
        end

        unique case (ctl.fin)
            rvcc_pkg::FIN_PASS: begin vis_new = 1'b1;    chk_new = 1'b0; end
            rvcc_pkg::FIN_HIDE: begin vis_new = 1'b0;    chk_new = 1'b1; end
            rvcc_pkg::FIN_SHOW: begin vis_new = 1'b1;    chk_new = 1'b1; end
            rvcc_pkg::FIN_CONE: begin vis_new = cone_ok; chk_new = 1'b1; end
            default:            begin vis_new = 1'b0;    chk_new = 1'b0; end
        endcase

        count_base = fs_reg ? '0 : count_reg;
        if (vis_new && chk_new && (count_base < COUNT_CAP))
        begin
            count_next = count_base + 11'd1;
        end
        else
        begin
            count_next = count_base;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= 16'sd16384;
            cos_reg    <= 16'sd10385;
            cull_reg   <= 1'b1;
        end
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                rvcc_pkg::REG_CAM_X:       cam_reg[0] <= $signed(cfg_data);
                rvcc_pkg::REG_CAM_Y:       cam_reg[1] <= $signed(cfg_data);
                rvcc_pkg::REG_CAM_Z:       cam_reg[2] <= $signed(cfg_data);
                rvcc_pkg::REG_DIR_X:       dir_reg[0] <= $signed(cfg_data[15:0]);
                rvcc_pkg::REG_DIR_Y:       dir_reg[1] <= $signed(cfg_data[15:0]);
                rvcc_pkg::REG_DIR_Z:       dir_reg[2] <= $signed(cfg_data[15:0]);
                rvcc_pkg::REG_COS_FOV:     cos_reg    <= $signed(cfg_data[15:0]);
                rvcc_pkg::REG_CULL_ENABLE: cull_reg   <= cfg_data[0];
                default:                   cull_reg   <= cull_reg;
            endcase
        end
    end

    // Sequencer control and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= rvcc_pkg::STEP_FIRST;
            ovalid_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_go)
            begin
                busy_reg <= 1'b1;
                step_reg <= rvcc_pkg::STEP_FIRST;
            end
            else if (fin_go)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                step_reg <= step_next;
            end

            if (fin_go)
            begin
                ovalid_reg <= 1'b1;
                count_reg  <= count_next;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            fs_reg      <= room.frame_start;
            room_reg[0] <= room.room_x;
            room_reg[1] <= room.room_y;
            room_reg[2] <= room.room_z;
            size_reg[0] <= room.size_x;
            size_reg[1] <= room.size_y;
            size_reg[2] <= room.size_z;
        end

        if (fin_go)
        begin
            vis_reg <= vis_new;
            chk_reg <= chk_new;
        end

        if (advance)
        begin
            prod_reg <= mul_a * mul_b;

            for (int i = 0; i < 3; i++)
            begin
                if (ctl.dp == rvcc_pkg::DP_CORNER)
                begin
                    // Test corner: take the far side wherever the view looks forward.
                    dlt_reg[i] <= 26'(room_reg[i])
                                  + ((dir_reg[i] > 16'sd0) ? $signed({3'd0, size_reg[i]})
                                                           : 26'sd0);
                end
                else if (ctl.dp == rvcc_pkg::DP_DELTA)
                begin
                    dlt_reg[i] <= dlt_reg[i] - 26'(cam_reg[i]);
                end
            end

            case (ctl.acc)
                rvcc_pkg::ACC_LOAD: acc_reg <= prod_reg;
                rvcc_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg;
                default:            acc_reg <= acc_reg;
            endcase

            // The view-distance branch leaves before l2 would overflow its register.
            case (ctl.lat)
                rvcc_pkg::LAT_L2:  l2_reg  <= acc_reg[rvcc_pkg::L2_W-1:0];
                rvcc_pkg::LAT_D:   d_reg   <= acc_reg[31:0];
                rvcc_pkg::LAT_CC:  cc2_reg <= prod_reg[30:0];
                rvcc_pkg::LAT_LHS: lhs_reg <= prod_reg[61:0];
                default:           lhs_reg <= lhs_reg;
            endcase
        end
    end

endmodule
